// ----- rtl/core/ovn_pkg.sv -----
// ovn_pkg: shared types, constants and the cosine factor table
// for the octave value noise generator; no dependencies
`timescale 1ns / 1ps

package ovn_pkg;

  localparam int GRID_SIDE_DEF   = 256;
  localparam int MAX_OCTAVES_DEF = 8;

  localparam int AMP_W = 49;
  localparam logic [AMP_W-1:0] AMP_ONE   = AMP_W'(64'd1 << 32);
  localparam logic [AMP_W-1:0] AMP_LIMIT = AMP_W'(64'd1 << 40);

  localparam logic [1:0] REG_OCTAVE_COUNT = 2'd0;
  localparam logic [1:0] REG_INTERP_COS   = 2'd1;
  localparam logic [1:0] REG_PERSISTENCE  = 2'd2;
  localparam logic [1:0] REG_TWO_DIM      = 2'd3;

  localparam logic OPER_WRITE = 1'b0;
  localparam logic OPER_EVAL  = 1'b1;

  // blend operand selects
  localparam logic [1:0] BL_TOP = 2'd0;
  localparam logic [1:0] BL_BOT = 2'd1;
  localparam logic [1:0] BL_VERT = 2'd2;
  localparam logic [1:0] BL_ROW = 2'd3;

  typedef struct packed {
    logic [3:0]  octave_count;
    logic        interp_cosine;
    logic [15:0] persistence_q8_8;
    logic        two_dimensional;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_WRITE,
    OP_START,
    OP_READ,
    OP_BLEND,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_ACC,
    OP_DIV_AMP,
    OP_AMP_TAKE,
    OP_SCALE,
    OP_NEXT,
    OP_DIV_FIN,
    OP_RESULT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] sel;
  } cmd_t;

  typedef struct packed {
    logic two_d;
    logic last_octave;
    logic amp_over;
    logic div_busy;
  } status_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_BL0,
    ST_BL1,
    ST_BL2,
    ST_BL_ROW,
    ST_MLO,
    ST_MHI,
    ST_ACC,
    ST_DAMP,
    ST_WAMP,
    ST_SCALE,
    ST_DFIN,
    ST_WFIN
  } state_t;

  typedef logic [15:0] cos_tab_t [256];

  // round(65536 * sin^2(pi*i/512)) from a fixed q30 taylor series
  function automatic logic [15:0] sine_squared(input logic [8:0] i);
    logic [63:0] a;
    logic [63:0] a2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] f;
    a    = (64'd3373259426 * 64'(i)) >> 9;
    a2   = (a * a) >> 30;
    term = a;
    sum  = a;
    term = ((term * a2) >> 30) / 64'd6;
    sum  = sum - term;
    term = ((term * a2) >> 30) / 64'd20;
    sum  = sum + term;
    term = ((term * a2) >> 30) / 64'd42;
    sum  = sum - term;
    term = ((term * a2) >> 30) / 64'd72;
    sum  = sum + term;
    term = ((term * a2) >> 30) / 64'd110;
    sum  = sum - term;
    term = ((term * a2) >> 30) / 64'd156;
    sum  = sum + term;
    term = ((term * a2) >> 30) / 64'd210;
    sum  = sum - term;
    if (sum > (64'd1 << 30)) begin
      sum = 64'd1 << 30;
    end
    f = (sum * sum + (64'd1 << 43)) >> 44;
    return (f > 64'd65535) ? 16'hFFFF : f[15:0];
  endfunction

  function automatic cos_tab_t build_cos_tab();
    cos_tab_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = sine_squared(9'(i));
    end
    return t;
  endfunction

  localparam cos_tab_t COS_TAB = build_cos_tab();

endpackage

// ----- rtl/core/octave_value_noise_generator.sv -----
// octave_value_noise_generator: top level, configuration registers and
// assertions; uses ovn_pkg, ovn_ctrl, ovn_datapath
//
// Input channel (in_*): one request per item. A write request (operation 0)
// stores seed_value at (coord_x, coord_y) and gives no result. An
// evaluate request (operation 1) gives one noise_value on the out_*
// channel. Configuration (cfg_*) is always ready; the user must see that it
// is written only while the block is idle, which the block does not enforce.
// An evaluate runs each octave in turn: it reads the lattice seeds (four
// in 2D, two in 1D), blends them, multiplies by the amplitude and
// accumulates; each octave but the last then divides the amplitude by the
// persistence on the shared divider (a dividend of 58 + clog2(MAX_OCTAVES)
// bits, 61 by default) and rescales while the amplitude is over its limit;
// the last starts the final normalizing division instead.
// Items are processed one at a time; the divider and the single seed
// memory read port set the rate.
// Reset clears the control state and sets the configuration to its reset
// values; the seed memory holds nothing valid until written.
// A stalled receiver holds the result register; the next item is still
// accepted, and its result waits until the register is free.
`timescale 1ns / 1ps

module octave_value_noise_generator #(
  parameter int GRID_SIDE   = ovn_pkg::GRID_SIDE_DEF,
  parameter int MAX_OCTAVES = ovn_pkg::MAX_OCTAVES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [7:0]  in_coord_x,
  input  logic [7:0]  in_coord_y,
  input  logic [15:0] in_seed_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_noise_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import ovn_pkg::*;

  localparam int OCT_W = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;

  cfg_t       cfg_r;
  logic [3:0] oct_lim;
  logic [OCT_W-1:0] oct_last;
  cmd_t       cmd;
  status_t    status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.octave_count     <= 4'd1;
      cfg_r.interp_cosine    <= 1'b0;
      cfg_r.persistence_q8_8 <= 16'd512;
      cfg_r.two_dimensional  <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_OCTAVE_COUNT: cfg_r.octave_count     <= cfg_data[3:0];
        REG_INTERP_COS:   cfg_r.interp_cosine    <= cfg_data[0];
        REG_PERSISTENCE:  cfg_r.persistence_q8_8 <= cfg_data;
        REG_TWO_DIM:      cfg_r.two_dimensional  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (cfg_r.octave_count == 4'd0) begin
      oct_lim = 4'd0;
    end else if (32'(cfg_r.octave_count) > MAX_OCTAVES) begin
      oct_lim = 4'(MAX_OCTAVES - 1);
    end else begin
      oct_lim = cfg_r.octave_count - 4'd1;
    end
  end

  assign oct_last = OCT_W'(oct_lim);

  ovn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (in_operation),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  ovn_datapath #(
    .GRID_SIDE   (GRID_SIDE),
    .MAX_OCTAVES (MAX_OCTAVES),
    .OCT_W       (OCT_W)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .cfg         (cfg_r),
    .oct_last    (oct_last),
    .coord_x     (in_coord_x),
    .coord_y     (in_coord_y),
    .seed_value  (in_seed_value),
    .noise_value (out_noise_value)
  );

`ifndef NO_ASSERTIONS
  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_operation == OPER_EVAL) |=> !in_ready)
    else $error("evaluate request did not occupy the sequencer");

  a_write_single: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_operation == OPER_WRITE) |=> in_ready)
    else $error("seed write took more than one cycle");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");
`endif

endmodule

// ----- rtl/core/ovn_divider.sv -----
// ovn_divider: restoring divider, one quotient bit per cycle
// depends on nothing but its parameters
`timescale 1ns / 1ps

module ovn_divider #(
  parameter int NUM_W = 61,
  parameter int DEN_W = 44
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             busy,
  output logic [NUM_W-1:0] quotient
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem_r, num_r[NUM_W-1]};
  assign fits  = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(NUM_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend;
      den_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? DEN_W'(trial - {1'b0, den_r}) : DEN_W'(trial);
      num_r <= {num_r[NUM_W-2:0], fits};
    end
  end

  assign busy     = busy_r;
  assign quotient = num_r;

endmodule

// ----- rtl/core/ovn_datapath.sv -----
// ovn_datapath: seed memory, lattice addressing, blend unit, octave
// accumulation and result register; uses ovn_pkg and ovn_divider
`timescale 1ns / 1ps

module ovn_datapath #(
  parameter int GRID_SIDE   = ovn_pkg::GRID_SIDE_DEF,
  parameter int MAX_OCTAVES = ovn_pkg::MAX_OCTAVES_DEF,
  parameter int OCT_W       = 3
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ovn_pkg::cmd_t       cmd,
  output ovn_pkg::status_t    status,
  input  ovn_pkg::cfg_t       cfg,
  input  logic [OCT_W-1:0]    oct_last,
  input  logic [7:0]          coord_x,
  input  logic [7:0]          coord_y,
  input  logic [15:0]         seed_value,
  output logic [15:0]         noise_value
);
  import ovn_pkg::*;

  localparam int SIDE_W  = $clog2(GRID_SIDE);
  localparam int ACC_W   = 41 + $clog2(MAX_OCTAVES);
  localparam int NOISE_W = ACC_W + 16;
  localparam int DIV_N   = NOISE_W + 1;
  localparam int DEPTH   = GRID_SIDE * GRID_SIDE;

  logic [15:0] mem [DEPTH];

  logic [SIDE_W-1:0]  x_r, y_r;
  logic [15:0]        d_r [4];
  logic [15:0]        top_r, bot_r, s_r;
  logic [36:0]        plo_r;
  logic [35:0]        phi_r;
  logic [AMP_W-1:0]   amp_r;
  logic [NOISE_W-1:0] noise_r;
  logic [ACC_W-1:0]   acc_r;
  logic [OCT_W-1:0]   oct_r;
  logic [15:0]        out_r;

  logic [SIDE_W-1:0] cx, cy;
  logic [3:0]        sh;
  logic [SIDE_W-1:0] mask, wave_bit;
  logic [SIDE_W-1:0] offx, offy, x1, x2, y1, y2;
  logic [15:0]       wx, wy;
  logic [SIDE_W-1:0] rd_row, rd_col;

  logic [15:0]        bl_a, bl_b, bl_w, bl_res;
  logic signed [16:0] bl_diff;
  logic signed [34:0] bl_sum;

  logic               div_start;
  logic [DIV_N-1:0]   div_num;
  logic [ACC_W-1:0]   div_den;
  logic               div_busy;
  logic [DIV_N-1:0]   div_q;
  logic [ACC_W-1:0]   pers;

  assign cx = SIDE_W'(32'(coord_x) % GRID_SIDE);
  assign cy = SIDE_W'(32'(coord_y) % GRID_SIDE);

  function automatic logic [15:0] weight(input logic [SIDE_W-1:0] off,
                                         input logic [3:0] s,
                                         input logic cosine);
    logic [7:0] idx;
    idx = 8'({off, 8'b0} >> s);
    return cosine ? COS_TAB[idx] : 16'({off, 16'b0} >> s);
  endfunction

  always_comb begin
    if (32'(oct_r) >= SIDE_W) begin
      sh = '0;
    end else begin
      sh = 4'(SIDE_W - 32'(oct_r));
    end
  end

  assign mask     = ~({SIDE_W{1'b1}} << sh);
  assign wave_bit = SIDE_W'(1) << sh;
  assign offx     = x_r & mask;
  assign offy     = y_r & mask;
  assign x1       = x_r & ~mask;
  assign y1       = y_r & ~mask;
  assign x2       = x1 + wave_bit;
  assign y2       = y1 + wave_bit;
  assign wx       = weight(offx, sh, cfg.interp_cosine);
  assign wy       = weight(offy, sh, cfg.interp_cosine);

  always_comb begin
    rd_col = cmd.sel[0] ? x2 : x1;
    if (!cfg.two_dimensional) begin
      rd_row = '0;
    end else begin
      rd_row = cmd.sel[1] ? y2 : y1;
    end
  end

  // a + ((b - a) * w + half) >> 16
  always_comb begin
    unique case (cmd.sel)
      BL_TOP:  begin bl_a = d_r[0]; bl_b = d_r[1]; bl_w = wx; end
      BL_BOT:  begin bl_a = d_r[2]; bl_b = d_r[3]; bl_w = wx; end
      BL_VERT: begin bl_a = top_r;  bl_b = bot_r;  bl_w = wy; end
      default: begin bl_a = d_r[0]; bl_b = d_r[1]; bl_w = wx; end
    endcase
    bl_diff = $signed({1'b0, bl_b}) - $signed({1'b0, bl_a});
    bl_sum  = $signed({3'b0, bl_a, 16'b0}) + 35'(bl_diff * $signed({1'b0, bl_w}))
              + 35'sd32768;
    bl_res  = bl_sum[31:16];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_WRITE) begin
      mem[{cy, cx}] <= seed_value;
    end
    if (cmd.op == OP_READ) begin
      d_r[cmd.sel] <= mem[{rd_row, rd_col}];
    end
  end

  assign pers = (cfg.persistence_q8_8 == '0) ? ACC_W'(1) : ACC_W'(cfg.persistence_q8_8);

  always_comb begin
    div_start = 1'b0;
    div_num   = DIV_N'({amp_r, 8'b0});
    div_den   = pers;
    if (cmd.op == OP_DIV_AMP) begin
      div_start = 1'b1;
    end else if (cmd.op == OP_DIV_FIN) begin
      div_start = 1'b1;
      div_num   = DIV_N'(noise_r) + DIV_N'(acc_r >> 1);
      div_den   = acc_r;
    end
  end

  ovn_divider #(
    .NUM_W (DIV_N),
    .DEN_W (ACC_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .busy     (div_busy),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_START: begin
        x_r     <= cx;
        y_r     <= cy;
        amp_r   <= AMP_ONE;
        noise_r <= '0;
        acc_r   <= '0;
        oct_r   <= '0;
      end
      OP_BLEND: begin
        unique case (cmd.sel)
          BL_TOP:  top_r <= bl_res;
          BL_BOT:  bot_r <= bl_res;
          default: s_r   <= bl_res;
        endcase
      end
      OP_MUL_LO: plo_r <= 37'(s_r * amp_r[20:0]);
      OP_MUL_HI: phi_r <= 36'(s_r * amp_r[40:21]);
      OP_ACC: begin
        noise_r <= noise_r + NOISE_W'(plo_r) + (NOISE_W'(phi_r) << 21);
        acc_r   <= acc_r + ACC_W'(amp_r);
      end
      OP_AMP_TAKE: amp_r <= AMP_W'(div_q);
      OP_SCALE: begin
        amp_r   <= amp_r >> 8;
        noise_r <= noise_r >> 8;
        acc_r   <= acc_r >> 8;
      end
      OP_NEXT: oct_r <= oct_r + 1'b1;
      OP_RESULT: begin
        if (acc_r == '0) begin
          out_r <= '0;
        end else if (div_q > DIV_N'(16'hFFFF)) begin
          out_r <= 16'hFFFF;
        end else begin
          out_r <= div_q[15:0];
        end
      end
      default: ;
    endcase
  end

  assign status.two_d       = cfg.two_dimensional;
  assign status.last_octave = (oct_r == oct_last);
  assign status.amp_over    = (amp_r > AMP_LIMIT);
  assign status.div_busy    = div_busy;
  assign noise_value        = out_r;

endmodule

// ----- rtl/core/ovn_ctrl.sv -----
// ovn_ctrl: sequencer for seed writes and octave evaluation, owns the
// input and result handshakes; uses ovn_pkg
`timescale 1ns / 1ps

module ovn_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             operation,
  output logic             out_valid,
  input  logic             out_ready,
  output ovn_pkg::cmd_t    cmd,
  input  ovn_pkg::status_t status
);
  import ovn_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = OP_IDLE;
    cmd.sel       = '0;
    in_ready      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (operation == OPER_WRITE) begin
            cmd.op = OP_WRITE;
          end else begin
            cmd.op    = OP_START;
            state_nxt = ST_RD0;
          end
        end
      end
      ST_RD0: begin
        cmd.op = OP_READ; cmd.sel = 2'd0; state_nxt = ST_RD1;
      end
      ST_RD1: begin
        cmd.op    = OP_READ;
        cmd.sel   = 2'd1;
        state_nxt = status.two_d ? ST_RD2 : ST_BL_ROW;
      end
      ST_RD2: begin
        cmd.op = OP_READ; cmd.sel = 2'd2; state_nxt = ST_RD3;
      end
      ST_RD3: begin
        cmd.op = OP_READ; cmd.sel = 2'd3; state_nxt = ST_BL0;
      end
      ST_BL0: begin
        cmd.op = OP_BLEND; cmd.sel = BL_TOP; state_nxt = ST_BL1;
      end
      ST_BL1: begin
        cmd.op = OP_BLEND; cmd.sel = BL_BOT; state_nxt = ST_BL2;
      end
      ST_BL2: begin
        cmd.op = OP_BLEND; cmd.sel = BL_VERT; state_nxt = ST_MLO;
      end
      ST_BL_ROW: begin
        cmd.op = OP_BLEND; cmd.sel = BL_ROW; state_nxt = ST_MLO;
      end
      ST_MLO: begin
        cmd.op = OP_MUL_LO; state_nxt = ST_MHI;
      end
      ST_MHI: begin
        cmd.op = OP_MUL_HI; state_nxt = ST_ACC;
      end
      ST_ACC: begin
        cmd.op    = OP_ACC;
        state_nxt = status.last_octave ? ST_DFIN : ST_DAMP;
      end
      ST_DAMP: begin
        cmd.op = OP_DIV_AMP; state_nxt = ST_WAMP;
      end
      ST_WAMP: begin
        if (!status.div_busy) begin
          cmd.op    = OP_AMP_TAKE;
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: begin
        if (status.amp_over) begin
          cmd.op = OP_SCALE;
        end else begin
          cmd.op    = OP_NEXT;
          state_nxt = ST_RD0;
        end
      end
      ST_DFIN: begin
        cmd.op = OP_DIV_FIN; state_nxt = ST_WFIN;
      end
      ST_WFIN: begin
        if (!status.div_busy && (!out_valid_r || out_ready)) begin
          cmd.op        = OP_RESULT;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// ----- tb/tb_octave_value_noise_generator.sv -----
// tb_octave_value_noise_generator: self-checking testbench for the octave value noise
// generator; predicts each evaluate from a local seed grid copy; uses ovn_pkg and the dut
`timescale 1ns / 1ps

module tb_octave_value_noise_generator;
  import ovn_pkg::*;

  localparam int SIDE = 256;
  localparam int OCT_MAX = 8;
  localparam int SETTLE = 800;
  localparam longint CYCLE_LIMIT = 4000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_operation = OPER_WRITE;
  logic [7:0] in_coord_x = '0;
  logic [7:0] in_coord_y = '0;
  logic [15:0] in_seed_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [15:0] out_noise_value;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  octave_value_noise_generator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_operation(in_operation),
    .in_coord_x(in_coord_x), .in_coord_y(in_coord_y), .in_seed_value(in_seed_value),
    .out_valid(out_valid), .out_ready(out_ready), .out_noise_value(out_noise_value),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  logic [15:0] seed_copy [SIDE*SIDE];
  bit seed_known [SIDE*SIDE];
  logic [15:0] cos_factor [256];
  logic [3:0] m_octaves;
  logic m_cosine;
  logic [15:0] m_persist;
  logic m_two_d;

  logic [15:0] noise_expected [$];
  int errors = 0;
  bit idle_on = 1'b1;
  int hold_req_n = 0;
  int hold_seen = 0;
  int hold_cnt = 0;
  int stall_cnt = 0;
  longint cycles = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_octave_value_noise_generator: done, errors");
      $finish;
    end
  end

  function automatic logic [15:0] sin_sq(int i);
    logic [63:0] a, a2, term, sum, f;
    a = (64'd3373259426 * 64'(i)) >> 9;
    a2 = (a * a) >> 30;
    term = a;
    sum = a;
    for (int k = 1; k <= 7; k++) begin
      term = ((term * a2) >> 30) / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) sum = sum - term;
      else sum = sum + term;
    end
    if (sum > (64'd1 << 30)) sum = 64'd1 << 30;
    f = (sum * sum + (64'd1 << 43)) >> 44;
    return (f > 64'd65535) ? 16'hFFFF : f[15:0];
  endfunction

  function automatic logic [31:0] weight(int off, int wave);
    if (m_cosine) return 32'(cos_factor[((off << 8) / wave) & 255]);
    return 32'(((off << 16) / wave) & 32'hFFFF);
  endfunction

  function automatic logic [31:0] mix(logic [31:0] a, logic [31:0] b, logic [31:0] w);
    logic [63:0] v;
    v = 64'(a) * 64'(32'd65536 - w) + 64'(b) * 64'(w) + 64'd32768;
    return 32'(v >> 16);
  endfunction

  function automatic logic [31:0] seed_rd(int row, int col);
    return 32'(seed_copy[(row % SIDE) * SIDE + (col % SIDE)]);
  endfunction

  function automatic int octaves_used();
    int n;
    n = m_octaves;
    if (n == 0) n = 1;
    if (n > OCT_MAX) n = OCT_MAX;
    return n;
  endfunction

  // coordinates near both ends of an axis, so lattice seeds are shared
  function automatic int pick_coord();
    int v;
    v = $urandom_range(0, 31);
    return (v < 16) ? v : v + 224;
  endfunction

  function automatic logic [15:0] noise_at(int x, int y);
    int n, wave, x1, x2, y1, y2;
    logic [31:0] wx, wy, s, top, bot, p;
    logic [63:0] amp, acc, sum, r;
    n = octaves_used();
    p = (m_persist == 0) ? 32'd1 : 32'(m_persist);
    amp = 64'd1 << 32;
    acc = 0;
    sum = 0;
    for (int o = 0; o < n; o++) begin
      wave = SIDE >> o;
      if (wave == 0) wave = 1;
      x1 = (x / wave) * wave;
      x2 = (x1 + wave) % SIDE;
      wx = weight(x - x1, wave);
      if (m_two_d) begin
        y1 = (y / wave) * wave;
        y2 = (y1 + wave) % SIDE;
        wy = weight(y - y1, wave);
        top = mix(seed_rd(y1, x1), seed_rd(y1, x2), wx);
        bot = mix(seed_rd(y2, x1), seed_rd(y2, x2), wx);
        s = mix(top, bot, wy);
      end else begin
        s = mix(seed_rd(0, x1), seed_rd(0, x2), wx);
      end
      sum = sum + 64'(s) * amp;
      acc = acc + amp;
      if (o + 1 < n) begin
        amp = (amp << 8) / 64'(p);
        while (amp > (64'd1 << 40)) begin
          amp = amp >> 8;
          sum = sum >> 8;
          acc = acc >> 8;
        end
      end
    end
    if (acc == 0) return 16'd0;
    r = (sum + acc / 2) / acc;
    return (r > 64'd65535) ? 16'hFFFF : r[15:0];
  endfunction

  // result side: compare in order
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      if (noise_expected.size() == 0) begin
        errors <= errors + 1;
        if (errors < 10) $display("unexpected result noise_value=%0d", out_noise_value);
      end else begin
        if (out_noise_value !== noise_expected[0]) begin
          errors <= errors + 1;
          if (errors < 10)
            $display("noise_value mismatch: expected %0d actual %0d",
                     noise_expected[0], out_noise_value);
        end
        noise_expected.pop_front();
      end
    end
  end

  // result side: random stalls and a long hold on request
  always @(posedge clk) begin
    if (hold_seen != hold_req_n) begin
      hold_seen <= hold_req_n;
      hold_cnt <= 3000;
      out_ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else if (stall_cnt > 0) begin
      stall_cnt <= stall_cnt - 1;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_cnt <= $urandom_range(0, 8);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_item(logic op, int x, int y, logic [15:0] seed);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_coord_x <= 8'(x);
    in_coord_y <= 8'(y);
    in_seed_value <= seed;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op == OPER_WRITE) begin
      seed_copy[y * SIDE + x] = seed;
      seed_known[y * SIDE + x] = 1'b1;
    end else begin
      noise_expected.push_back(noise_at(x, y));
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (noise_expected.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_OCTAVE_COUNT: m_octaves = val[3:0];
      REG_INTERP_COS: m_cosine = val[0];
      REG_PERSISTENCE: m_persist = val;
      REG_TWO_DIM: m_two_d = val[0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(logic [3:0] oc, logic ic, logic [15:0] pers, logic td);
    drain();
    repeat (SETTLE) @(posedge clk);
    write_reg(REG_OCTAVE_COUNT, {12'($urandom_range(0, 4095)), oc});
    write_reg(REG_INTERP_COS, {15'($urandom), ic});
    write_reg(REG_PERSISTENCE, pers);
    write_reg(REG_TWO_DIM, {15'($urandom), td});
    cfg_valid <= 1'b0;
  endtask

  task automatic fill_corner(int row, int col);
    if (!seed_known[row * SIDE + col]) send_item(OPER_WRITE, col, row, 16'($urandom));
  endtask

  // writes every lattice seed the point needs that is not yet known, then evaluates it
  task automatic eval_point(int x, int y);
    int wave, x1, x2, y1, y2;
    for (int o = 0; o < octaves_used(); o++) begin
      wave = SIDE >> o;
      x1 = (x / wave) * wave;
      x2 = (x1 + wave) % SIDE;
      if (m_two_d) begin
        y1 = (y / wave) * wave;
        y2 = (y1 + wave) % SIDE;
        fill_corner(y1, x1);
        fill_corner(y1, x2);
        fill_corner(y2, x1);
        fill_corner(y2, x2);
      end else begin
        fill_corner(0, x1);
        fill_corner(0, x2);
      end
    end
    send_item(OPER_EVAL, x, y, 16'($urandom));
  endtask

  task automatic random_item();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 2) send_item(OPER_WRITE, $urandom_range(0, 255), $urandom_range(0, 255),
                            16'($urandom));
    else if (pick < 3) eval_point($urandom_range(0, 1) ? 0 : 255, pick_coord());
    else eval_point(pick_coord(), pick_coord());
  endtask

  task automatic random_setting();
    logic [15:0] pers;
    case ($urandom_range(0, 5))
      0: pers = 16'd13;
      1: pers = 16'hFFFF;
      2: pers = 16'd0;
      3: pers = 16'd256;
      default: pers = 16'($urandom_range(13, 2048));
    endcase
    apply_setting(4'($urandom_range(0, 15)), 1'($urandom), pers, 1'($urandom));
  endtask

  task automatic test_directed();
    send_item(OPER_WRITE, 0, 0, 16'd0);
    send_item(OPER_WRITE, 255, 255, 16'hFFFF);
    send_item(OPER_WRITE, 0, 255, 16'hFFFF);
    send_item(OPER_WRITE, 255, 0, 16'd0);
    eval_point(0, 0);
    eval_point(255, 255);
    eval_point(128, 7);
    apply_setting(4'd15, 1'b1, 16'd0, 1'b1);
    eval_point(255, 255);
    eval_point(1, 254);
    apply_setting(4'd0, 1'b1, 16'hFFFF, 1'b0);
    eval_point(255, 200);
    eval_point(0, 0);
    apply_setting(4'd8, 1'b0, 16'd13, 1'b0);
    eval_point(255, 3);
    eval_point(129, 255);
    apply_setting(4'd8, 1'b1, 16'd1, 1'b1);
    eval_point(77, 255);
  endtask

  task automatic test_random_settings();
    for (int ph = 0; ph < 8; ph++) begin
      random_setting();
      repeat (60) random_item();
    end
  endtask

  task automatic test_backpressure();
    apply_setting(4'd2, 1'b0, 16'd512, 1'b1);
    hold_req_n = hold_req_n + 1;
    repeat (20) random_item();
  endtask

  task automatic test_drain_pause();
    apply_setting(4'd4, 1'b1, 16'd300, 1'b1);
    repeat (30) random_item();
    drain();
    repeat (30) random_item();
  endtask

  task automatic test_no_idle();
    random_setting();
    idle_on = 1'b0;
    repeat (100) random_item();
  endtask

  initial begin
    for (int i = 0; i < 256; i++) cos_factor[i] = sin_sq(i);
    for (int i = 0; i < SIDE * SIDE; i++) begin
      seed_copy[i] = '0;
      seed_known[i] = 1'b0;
    end
    m_octaves = 4'd1;
    m_cosine = 1'b0;
    m_persist = 16'd512;
    m_two_d = 1'b1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_settings();
    test_backpressure();
    test_drain_pause();
    test_no_idle();
    drain();
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("tb_octave_value_noise_generator: done, clean");
    end else begin
      $display("tb_octave_value_noise_generator: done, errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/ovn_pkg.sv
rtl/core/ovn_divider.sv
rtl/core/ovn_datapath.sv
rtl/core/ovn_ctrl.sv
rtl/core/octave_value_noise_generator.sv
tb/tb_octave_value_noise_generator.sv
